@@ hw/rtl/mrr_pkg.sv @@
`default_nettype none

package mrr_pkg;

    typedef enum logic [1:0] {
        MUL_ACC_BASE,
        MUL_BASE_BASE,
        MUL_ACC_ACC
    } mrr_mul_sel_t;

    typedef struct packed {
        logic         load;
        logic         reduce_step;
        logic         set_base;
        logic         split_step;
        logic         mul_start;
        mrr_mul_sel_t mul_sel;
        logic         acc_take;
        logic         base_take;
        logic         sq_take;
    } mrr_cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic n_eq2;
        logic n_odd;
        logic red_last;
        logic rem_zero;
        logic e_lsb;
        logic e_zero;
        logic s_zero;
        logic mul_done;
        logic acc_one;
        logic nontrivial;
    } mrr_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/miller_rabin_round.sv @@
// Channel    Direction  Handshake                      Word
// item       in         item_valid / item_stall        candidate, base
// verdict    out        verdict_valid / verdict_stall  composite
//
// Even candidates, candidates below two and the candidate two are answered at classification.
// Odd candidates are classified and the base is reduced modulo the candidate, then the
// power is formed by bit-serial modular multiplications, each done by the shift-and-add
// modular multiplier.
// Reset is asynchronous and active low and leaves the block idle with no verdict pending.
// A new word is accepted while a finished verdict still waits under verdict_stall.
`default_nettype none

module miller_rabin_round #(
    parameter int NUM_BITS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [NUM_BITS-1:0] candidate,
    input  logic [NUM_BITS-1:0] base,
    output logic                verdict_valid,
    input  logic                verdict_stall,
    output logic                composite
);

    import mrr_pkg::*;

    mrr_cmd_t  cmd;
    mrr_stat_t stat;

    mrr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .verdict_valid(verdict_valid),
        .verdict_stall(verdict_stall),
        .composite    (composite),
        .cmd          (cmd),
        .stat         (stat)
    );

    mrr_datapath #(
        .NUM_BITS(NUM_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .candidate(candidate),
        .base     (base),
        .stat     (stat)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mrr_mulmod.sv @@
`default_nettype none

module mrr_mulmod #(
    parameter int NUM_BITS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] op_a,
    input  logic [NUM_BITS-1:0] op_b,
    input  logic [NUM_BITS-1:0] modulus,
    output logic                done,
    output logic [NUM_BITS-1:0] prod
);

    logic [NUM_BITS-1:0] x_reg;
    logic [NUM_BITS-1:0] y_reg;
    logic [NUM_BITS-1:0] p_reg;
    logic                busy_reg;

    // Both operands are below the modulus, so one conditional subtract reduces the sum.
    function automatic logic [NUM_BITS-1:0] add_mod(
        input logic [NUM_BITS-1:0] p,
        input logic [NUM_BITS-1:0] q,
        input logic [NUM_BITS-1:0] m
    );
        logic [NUM_BITS:0] sum;
        logic [NUM_BITS:0] dif;
        sum = {1'b0, p} + {1'b0, q};
        dif = sum - {1'b0, m};
        return (sum >= {1'b0, m}) ? dif[NUM_BITS-1:0] : sum[NUM_BITS-1:0];
    endfunction

    assign done = busy_reg && (y_reg == '0);
    assign prod = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= op_a;
            y_reg <= op_b;
            p_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            if (y_reg[0])
            begin
                p_reg <= add_mod(p_reg, x_reg, modulus);
            end
            x_reg <= add_mod(x_reg, x_reg, modulus);
            y_reg <= y_reg >> 1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mrr_datapath.sv @@
`default_nettype none

module mrr_datapath #(
    parameter int NUM_BITS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mrr_pkg::mrr_cmd_t   cmd,
    input  logic [NUM_BITS-1:0] candidate,
    input  logic [NUM_BITS-1:0] base,
    output mrr_pkg::mrr_stat_t  stat
);

    import mrr_pkg::*;

    localparam int CNT_W = $clog2(NUM_BITS);

    logic [NUM_BITS-1:0] n_reg;
    logic [NUM_BITS-1:0] a_reg;
    logic [NUM_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] acc_reg;
    logic [NUM_BITS-1:0] e_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    s_reg;

    logic [NUM_BITS:0]   red_wide;
    logic [NUM_BITS:0]   red_sub;
    logic [NUM_BITS-1:0] red_next;
    logic [NUM_BITS-1:0] mul_x;
    logic [NUM_BITS-1:0] mul_y;
    logic [NUM_BITS-1:0] prod;
    logic                mul_done;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_ACC_BASE:
            begin
                mul_x = acc_reg;
                mul_y = a_reg;
            end
            MUL_BASE_BASE:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            MUL_ACC_ACC:
            begin
                mul_x = acc_reg;
                mul_y = acc_reg;
            end
            default:
            begin
                mul_x = acc_reg;
                mul_y = a_reg;
            end
        endcase
    end

    mrr_mulmod #(
        .NUM_BITS(NUM_BITS)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .op_a   (mul_x),
        .op_b   (mul_y),
        .modulus(n_reg),
        .done   (mul_done),
        .prod   (prod)
    );

    // The base is reduced one bit a cycle by restoring remainder steps.
    assign red_wide = {rem_reg, a_reg[NUM_BITS-1]};
    assign red_sub  = red_wide - {1'b0, n_reg};
    assign red_next = (red_wide >= {1'b0, n_reg}) ? red_sub[NUM_BITS-1:0]
                                                  : red_wide[NUM_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= candidate;
            a_reg   <= base;
            rem_reg <= '0;
            e_reg   <= candidate - NUM_BITS'(1);
            cnt_reg <= CNT_W'(NUM_BITS - 1);
            s_reg   <= '0;
        end
        else if (cmd.reduce_step)
        begin
            rem_reg <= red_next;
            a_reg   <= {a_reg[NUM_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.set_base)
        begin
            a_reg   <= rem_reg;
            acc_reg <= NUM_BITS'(1);
        end
        else if (cmd.split_step)
        begin
            e_reg <= e_reg >> 1;
            s_reg <= s_reg + CNT_W'(1);
        end
        else if (cmd.acc_take)
        begin
            acc_reg <= prod;
        end
        else if (cmd.base_take)
        begin
            a_reg <= prod;
            e_reg <= e_reg >> 1;
        end
        else if (cmd.sq_take)
        begin
            acc_reg <= prod;
            s_reg   <= s_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        stat.n_lt2      = (n_reg[NUM_BITS-1:1] == '0);
        stat.n_eq2      = (n_reg == NUM_BITS'(2));
        stat.n_odd      = n_reg[0];
        stat.red_last   = (cnt_reg == '0);
        stat.rem_zero   = (rem_reg == '0);
        stat.e_lsb      = e_reg[0];
        stat.e_zero     = (e_reg == '0);
        stat.s_zero     = (s_reg == '0);
        stat.mul_done   = mul_done;
        stat.acc_one    = (acc_reg == NUM_BITS'(1));
        stat.nontrivial = (prod == NUM_BITS'(1)) && (acc_reg != NUM_BITS'(1))
                          && (acc_reg != (n_reg - NUM_BITS'(1)));
    end

endmodule

`default_nettype wire

@@ hw/rtl/mrr_ctrl.sv @@
`default_nettype none

module mrr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    output logic               verdict_valid,
    input  logic               verdict_stall,
    output logic               composite,
    output mrr_pkg::mrr_cmd_t  cmd,
    input  mrr_pkg::mrr_stat_t stat
);

    import mrr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_REDUCE,
        ST_CHECK,
        ST_SPLIT,
        ST_POW,
        ST_MUL_ACC,
        ST_WAIT_ACC,
        ST_MUL_BASE,
        ST_WAIT_BASE,
        ST_SQ,
        ST_WAIT_SQ,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   verdict_reg;
    logic   verdict_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   composite_reg;
    logic   composite_next;

    assign item_stall    = (state_reg != ST_IDLE);
    assign verdict_valid = out_valid_reg;
    assign composite     = composite_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && verdict_stall;
        composite_next = composite_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (stat.n_eq2)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else if (stat.n_lt2 || !stat.n_odd)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (stat.red_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.rem_zero)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.set_base = 1'b1;
                    state_next   = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (stat.e_lsb)
                begin
                    state_next = ST_POW;
                end
                else
                begin
                    cmd.split_step = 1'b1;
                end
            end
            ST_POW:
            begin
                if (stat.e_zero)
                begin
                    state_next = ST_SQ;
                end
                else if (stat.e_lsb)
                begin
                    state_next = ST_MUL_ACC;
                end
                else
                begin
                    state_next = ST_MUL_BASE;
                end
            end
            ST_MUL_ACC:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_ACC_BASE;
                state_next    = ST_WAIT_ACC;
            end
            ST_WAIT_ACC:
            begin
                if (stat.mul_done)
                begin
                    cmd.acc_take = 1'b1;
                    state_next   = ST_MUL_BASE;
                end
            end
            ST_MUL_BASE:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_BASE_BASE;
                state_next    = ST_WAIT_BASE;
            end
            ST_WAIT_BASE:
            begin
                if (stat.mul_done)
                begin
                    cmd.base_take = 1'b1;
                    state_next    = ST_POW;
                end
            end
            ST_SQ:
            begin
                if (stat.s_zero)
                begin
                    verdict_next = !stat.acc_one;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_ACC_ACC;
                    state_next    = ST_WAIT_SQ;
                end
            end
            ST_WAIT_SQ:
            begin
                if (stat.mul_done)
                begin
                    if (stat.nontrivial)
                    begin
                        verdict_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        cmd.sq_take = 1'b1;
                        state_next  = ST_SQ;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !verdict_stall)
                begin
                    out_valid_next = 1'b1;
                    composite_next = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            composite_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
            composite_reg <= composite_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mrr_checker.sv @@
`default_nettype none

module mrr_checker #(
    parameter int NUM_BITS = 63
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_stall,
    input wire logic [NUM_BITS-1:0] candidate,
    input wire logic [NUM_BITS-1:0] base,
    input wire logic                verdict_valid,
    input wire logic                verdict_stall,
    input wire logic                composite
);

    // A stalled input word stays valid and keeps its value.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(candidate) && $stable(base))
        else $error("stalled input word changed");

    // A stalled verdict word stays valid and keeps its value.
    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && verdict_stall |=> verdict_valid && $stable(composite))
        else $error("stalled verdict word changed");

    // The block works on one word at a time once it is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not stalled after accepting a word");

    // A new verdict appears only as the block returns to idle.
    a_verdict_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict_valid) |-> !item_stall)
        else $error("verdict raised while still busy");

    // Leaving a busy period always leaves a verdict pending.
    a_idle_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(item_stall) |-> verdict_valid)
        else $error("block went idle without a verdict");

endmodule

bind miller_rabin_round mrr_checker #(.NUM_BITS(NUM_BITS)) u_mrr_checker (.*);

`default_nettype wire

@@ tb/sv/tb_miller_rabin_round.sv @@
`default_nettype none

module tb_miller_rabin_round;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 63;

    typedef struct {
        logic [NB-1:0] cand;
        logic [NB-1:0] wit;
        int unsigned   phase;
    } word_t;

    typedef struct {
        logic [NB-1:0] cand;
        logic [NB-1:0] wit;
        logic          composite;
        int unsigned   phase;
    } verdict_t;

    // Idle percentages per phase: none, sender only, receiver only, both.
    int unsigned send_idle [4] = '{0, 60, 0, 37};
    int unsigned recv_stall[4] = '{0, 0, 60, 37};

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          item_valid    = 1'b0;
    logic          item_stall;
    logic [NB-1:0] candidate     = '0;
    logic [NB-1:0] base          = '0;
    logic          verdict_valid;
    logic          verdict_stall = 1'b0;
    logic          composite;

    word_t       pending_words[$];
    verdict_t    expected_verdicts[$];
    logic        took        = 1'b0;
    int unsigned cur_phase   = 0;
    int unsigned stall_phase = 0;
    int unsigned errors      = 0;
    int unsigned seen_composite = 0;
    int unsigned seen_prime     = 0;

    miller_rabin_round #(
        .NUM_BITS(NB)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .candidate    (candidate),
        .base         (base),
        .verdict_valid(verdict_valid),
        .verdict_stall(verdict_stall),
        .composite    (composite)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] n);
        logic [63:0] gap;
        begin
            gap = n - y;
            if (x >= gap)
                return x - gap;
            return x + y;
        end
    endfunction

    function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] xs;
        logic [63:0] ys;
        begin
            acc = '0;
            xs  = x;
            ys  = y;
            while (ys != 0)
            begin
                if (ys[0])
                    acc = add_mod(acc, xs, n);
                xs = add_mod(xs, xs, n);
                ys = ys >> 1;
            end
            return acc;
        end
    endfunction

    function automatic logic [63:0] pow_mod(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] bs;
        logic [63:0] es;
        begin
            acc = 64'd1;
            bs  = b;
            es  = e;
            while (es != 0)
            begin
                if (es[0])
                    acc = mul_mod(acc, bs, n);
                bs = mul_mod(bs, bs, n);
                es = es >> 1;
            end
            return acc;
        end
    endfunction

    function automatic logic predict_composite(input logic [NB-1:0] cand,
                                               input logic [NB-1:0] wit);
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] odd;
        logic [63:0] x;
        logic [63:0] sq;
        int          twos;
        int          k;
        begin
            n = {1'b0, cand};
            a = {1'b0, wit};
            if (n < 2)
                return 1'b1;
            if (n == 2)
                return 1'b0;
            if (!n[0])
                return 1'b1;
            a = a % n;
            if (a == 0)
                return 1'b0;
            odd  = n - 1;
            twos = 0;
            while (!odd[0] && twos < 64)
            begin
                odd = odd >> 1;
                twos++;
            end
            x = pow_mod(a, odd, n);
            for (k = 0; k < twos; k++)
            begin
                sq = mul_mod(x, x, n);
                if (sq == 1 && x != 1 && x != n - 1)
                    return 1'b1;
                x = sq;
            end
            return x != 1;
        end
    endfunction

    function automatic logic [NB-1:0] rand_word();
        logic [63:0] r;
        begin
            r = {$urandom(), $urandom()};
            return r[NB-1:0];
        end
    endfunction

    function automatic logic is_prime(input logic [NB-1:0] n);
        int unsigned witnesses[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        int          i;
        begin
            if (n < 2)
                return 1'b0;
            for (i = 0; i < 12; i++)
            begin
                if (n == witnesses[i])
                    return 1'b1;
                if (predict_composite(n, NB'(witnesses[i])))
                    return 1'b0;
            end
            return 1'b1;
        end
    endfunction

    function automatic logic [NB-1:0] random_prime(input int unsigned bits);
        logic [NB-1:0] n;
        int            tries;
        begin
            n = 3;
            for (tries = 0; tries < 2000; tries++)
            begin
                n = rand_word() >> (NB - bits);
                n[bits-1] = 1'b1;
                n[0] = 1'b1;
                if (is_prime(n))
                    return n;
            end
            return n;
        end
    endfunction

    task automatic add_word(input logic [NB-1:0] c, input logic [NB-1:0] w,
                            input int unsigned phase);
        word_t item;
        begin
            item.cand  = c;
            item.wit   = w;
            item.phase = phase;
            pending_words.push_back(item);
        end
    endtask

    task automatic build_stimulus();
        logic [NB-1:0] all_ones;
        logic [NB-1:0] big_prime;
        logic [NB-1:0] c;
        logic [NB-1:0] w;
        logic [NB-1:0] p;
        logic [63:0]   span;
        int unsigned   sel;
        int unsigned   i;
        int unsigned   total;
        begin
            all_ones  = '1;
            big_prime = 63'd9223372036854775783;
            add_word(63'd0, rand_word(), 0);
            add_word(63'd1, all_ones, 0);
            add_word(63'd2, 63'd0, 0);
            add_word(63'd2, all_ones, 0);
            add_word(63'd4, 63'd3, 0);
            add_word(all_ones - 1, all_ones, 0);
            add_word(all_ones, 63'd2, 0);
            add_word(all_ones, 63'd0, 0);
            add_word(all_ones, all_ones, 0);
            add_word(big_prime, 63'd2, 0);
            add_word(big_prime, all_ones, 0);
            add_word(big_prime, big_prime, 0);
            add_word(big_prime, big_prime - 1, 0);
            add_word(63'd3, 63'd2, 0);
            add_word(63'd3, 63'd6, 0);
            add_word(63'd5, 63'd1, 0);
            add_word(63'd7, 63'd6, 0);
            add_word(63'd9, 63'd8, 0);
            add_word(63'd561, 63'd2, 0);
            add_word(63'd2047, 63'd2, 0);
            add_word(63'd2047, 63'd3, 0);
            add_word(63'd3215031751, 63'd2, 0);
            add_word(63'd1000000007, rand_word(), 0);
            add_word(63'd1000000007, 63'd2000000014, 0);

            total = 76;
            for (i = 0; i < total; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 30)
                begin
                    c = random_prime($urandom_range(3, NB));
                    w = rand_word() >> $urandom_range(0, NB - 1);
                end
                else if (sel < 50)
                begin
                    c = rand_word() >> $urandom_range(0, NB - 3);
                    c[0] = 1'b1;
                    w = rand_word();
                end
                else if (sel < 65)
                begin
                    p = random_prime($urandom_range(3, 31));
                    c = p * random_prime($urandom_range(3, 31));
                    w = rand_word() >> $urandom_range(0, NB - 1);
                end
                else if (sel < 80)
                begin
                    if ($urandom_range(0, 1) == 0)
                        c = random_prime($urandom_range(3, NB));
                    else
                        c = rand_word() | 63'd1;
                    if (c < 3)
                        c = 3;
                    case ($urandom_range(0, 2))
                        0: w = 1;
                        1: w = c - 1;
                        default:
                        begin
                            span = {1'b0, all_ones} / {1'b0, c};
                            if (span > 64'hFFFF_FFFF)
                                span = 64'hFFFF_FFFF;
                            w = c * NB'($urandom_range(0, span[31:0]));
                        end
                    endcase
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: c = NB'($urandom_range(0, 2));
                        1: c = rand_word() & ~63'd1;
                        default: c = rand_word();
                    endcase
                    w = rand_word();
                end
                add_word(c, w, (i * 4) / total);
            end
        end
    endtask

    always @(posedge clk)
    begin
        verdict_t exp_v;
        verdict_t new_v;
        took <= rst_n && item_valid && !item_stall;
        if (rst_n)
        begin
            if (verdict_valid && !verdict_stall)
            begin
                if (composite)
                    seen_composite++;
                else
                    seen_prime++;
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: extra verdict word: expected none, actual %0b",
                             $realtime, composite);
                    errors++;
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    if (composite !== exp_v.composite)
                    begin
                        $display("%0t: n=%0d a=%0d: expected %0b, actual %0b",
                                 $realtime, exp_v.cand, exp_v.wit, exp_v.composite,
                                 composite);
                        errors++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                new_v.cand      = candidate;
                new_v.wit       = base;
                new_v.composite = predict_composite(candidate, base);
                new_v.phase     = cur_phase;
                expected_verdicts.push_back(new_v);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid    <= 1'b0;
            verdict_stall <= 1'b0;
        end
        else
        begin
            if (!item_valid || took)
            begin
                if (pending_words.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle[pending_words[0].phase])
                begin
                    item_valid <= 1'b1;
                    candidate  <= pending_words[0].cand;
                    base       <= pending_words[0].wit;
                    cur_phase  <= pending_words[0].phase;
                    pending_words.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
            if (expected_verdicts.size() > 0)
                stall_phase = expected_verdicts[0].phase;
            else if (pending_words.size() > 0)
                stall_phase = pending_words[0].phase;
            else
                stall_phase = 0;
            verdict_stall <= ($urandom_range(0, 99) < recv_stall[stall_phase]);
        end
    end

    initial
    begin
        int unsigned total_words;
        build_stimulus();
        total_words = pending_words.size();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        while (pending_words.size() != 0 || item_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $display("%0t: %0d verdict words still expected: expected 0, actual %0d",
                     $realtime, expected_verdicts.size(), expected_verdicts.size());
            errors++;
        end
        $display("Checked %0d words under four idle patterns: %0d composite, %0d probably prime.",
                 total_words, seen_composite, seen_prime);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(64'd200_000_000);
        $display("%0t: timed out with %0d words queued and %0d verdicts expected",
                 $realtime, pending_words.size(), expected_verdicts.size());
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
